FILE: hw/rtl/kdq_pkg.sv
// Shared types and codes for the keyed deque with identifier lookup.
package kdq_pkg;

   // Operation codes
   localparam logic [2:0] OP_INS_FRONT = 3'd0;
   localparam logic [2:0] OP_INS_BACK  = 3'd1;
   localparam logic [2:0] OP_FIND      = 3'd2;
   localparam logic [2:0] OP_REM_FRONT = 3'd3;
   localparam logic [2:0] OP_REM_BACK  = 3'd4;
   localparam logic [2:0] OP_REM_KEY   = 3'd5;

   // Status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_EMPTY   = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_MISSING = 2'd3;

   typedef struct packed {
      logic [7:0]  letter;
      logic [7:0]  score;
      logic [15:0] ident;
   } entry_type;

   typedef struct packed {
      logic [1:0] status;
      entry_type  entry;
   } result_type;

   typedef struct packed {
      logic entry_we;
      logic prev_we;
      logic next_we;
      logic stack_we;
   } mem_we_type;

endpackage

FILE: hw/rtl/keyed_deque_with_id_lookup.sv
// Keyed deque with identifier lookup: top level with result register.
//
// Holds an ordered deque of up to DEPTH entries (letter, score, 16-bit
// identifier from a wrapping counter) and handles one item at a time.
// An insert, or a rejected, empty-list or unused operation, goes from its
// start step straight to its result; remove front and remove back pass
// a remove step first. Find walks the list from the front until the
// match or the last entry; remove by key first notes whether the back entry
// matches, then walks the same way and ends in the remove step. The walk
// reads one entry per cycle via the registered memory read port. Results
// wait in an output register; the next item is taken once the previous
// result has moved there. No clearing pass follows reset.
module keyed_deque_with_id_lookup #(
   parameter int DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_operation,
   input  logic [7:0]  req_letter,
   input  logic [7:0]  req_score,
   input  logic [15:0] req_key_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_entry_letter,
   output logic [7:0]  rsp_entry_score,
   output logic [15:0] rsp_entry_id,
   output logic [6:0]  rsp_entry_count
);
   import kdq_pkg::*;

   localparam int SW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic          res_valid;
   logic          res_take;
   result_type    res_data;
   logic [CW-1:0] res_count;

   mem_we_type    mem_we;
   logic [SW-1:0] link_raddr;
   logic [SW-1:0] stack_raddr;
   logic [SW-1:0] entry_waddr;
   entry_type     entry_wdata;
   logic [SW-1:0] prev_waddr;
   logic [SW-1:0] prev_wdata;
   logic [SW-1:0] next_waddr;
   logic [SW-1:0] next_wdata;
   logic [SW-1:0] stack_waddr;
   logic [SW-1:0] stack_wdata;
   entry_type     entry_rdata;
   logic [SW-1:0] prev_rdata;
   logic [SW-1:0] next_rdata;
   logic [SW-1:0] stack_rdata;

   logic          rsp_valid_ff;
   result_type    rsp_data_ff;
   logic [6:0]    rsp_count_ff;

   kdq_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_letter    (req_letter),
      .req_score     (req_score),
      .req_key_id    (req_key_id),
      .res_valid     (res_valid),
      .res_take      (res_take),
      .res_data      (res_data),
      .res_count     (res_count),
      .mem_we        (mem_we),
      .link_raddr    (link_raddr),
      .stack_raddr   (stack_raddr),
      .entry_waddr   (entry_waddr),
      .entry_wdata   (entry_wdata),
      .prev_waddr    (prev_waddr),
      .prev_wdata    (prev_wdata),
      .next_waddr    (next_waddr),
      .next_wdata    (next_wdata),
      .stack_waddr   (stack_waddr),
      .stack_wdata   (stack_wdata),
      .entry_rdata   (entry_rdata),
      .prev_rdata    (prev_rdata),
      .next_rdata    (next_rdata),
      .stack_rdata   (stack_rdata)
   );

   kdq_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock       (clock),
      .mem_we      (mem_we),
      .link_raddr  (link_raddr),
      .stack_raddr (stack_raddr),
      .entry_waddr (entry_waddr),
      .entry_wdata (entry_wdata),
      .prev_waddr  (prev_waddr),
      .prev_wdata  (prev_wdata),
      .next_waddr  (next_waddr),
      .next_wdata  (next_wdata),
      .stack_waddr (stack_waddr),
      .stack_wdata (stack_wdata),
      .entry_rdata (entry_rdata),
      .prev_rdata  (prev_rdata),
      .next_rdata  (next_rdata),
      .stack_rdata (stack_rdata)
   );

   // Move a finished result into the output register when it is free or being read
   assign res_take = res_valid && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Hold the result payload until the item is taken
   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_data_ff  <= res_data;
         rsp_count_ff <= 7'(res_count);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_data_ff.status;
   assign rsp_entry_letter = rsp_data_ff.entry.letter;
   assign rsp_entry_score  = rsp_data_ff.entry.score;
   assign rsp_entry_id     = rsp_data_ff.entry.ident;
   assign rsp_entry_count  = rsp_count_ff;

endmodule

FILE: hw/rtl/kdq_store.sv
// Entry, link and free-slot memories with registered read data.
module kdq_store #(
   parameter int DEPTH = 64
) (
   input  logic                          clock,
   input  kdq_pkg::mem_we_type           mem_we,
   input  logic [$clog2(DEPTH)-1:0]      link_raddr,
   input  logic [$clog2(DEPTH)-1:0]      stack_raddr,
   input  logic [$clog2(DEPTH)-1:0]      entry_waddr,
   input  kdq_pkg::entry_type            entry_wdata,
   input  logic [$clog2(DEPTH)-1:0]      prev_waddr,
   input  logic [$clog2(DEPTH)-1:0]      prev_wdata,
   input  logic [$clog2(DEPTH)-1:0]      next_waddr,
   input  logic [$clog2(DEPTH)-1:0]      next_wdata,
   input  logic [$clog2(DEPTH)-1:0]      stack_waddr,
   input  logic [$clog2(DEPTH)-1:0]      stack_wdata,
   output kdq_pkg::entry_type            entry_rdata,
   output logic [$clog2(DEPTH)-1:0]      prev_rdata,
   output logic [$clog2(DEPTH)-1:0]      next_rdata,
   output logic [$clog2(DEPTH)-1:0]      stack_rdata
);
   import kdq_pkg::*;

   localparam int SW = $clog2(DEPTH);

   entry_type         entry_mem_ff [DEPTH];
   logic [SW-1:0]     prev_mem_ff  [DEPTH];
   logic [SW-1:0]     next_mem_ff  [DEPTH];
   logic [SW-1:0]     stack_mem_ff [DEPTH];

   entry_type         entry_rd_ff;
   logic [SW-1:0]     prev_rd_ff;
   logic [SW-1:0]     next_rd_ff;
   logic [SW-1:0]     stack_rd_ff;

   // Write one address per memory per cycle
   always_ff @(posedge clock) begin
      if (mem_we.entry_we) begin
         entry_mem_ff[entry_waddr] <= entry_wdata;
      end
      if (mem_we.prev_we) begin
         prev_mem_ff[prev_waddr] <= prev_wdata;
      end
      if (mem_we.next_we) begin
         next_mem_ff[next_waddr] <= next_wdata;
      end
      if (mem_we.stack_we) begin
         stack_mem_ff[stack_waddr] <= stack_wdata;
      end
   end

   // Register read data; entry and links share one slot address
   always_ff @(posedge clock) begin
      entry_rd_ff <= entry_mem_ff[link_raddr];
      prev_rd_ff  <= prev_mem_ff[link_raddr];
      next_rd_ff  <= next_mem_ff[link_raddr];
      stack_rd_ff <= stack_mem_ff[stack_raddr];
   end

   assign entry_rdata = entry_rd_ff;
   assign prev_rdata  = prev_rd_ff;
   assign next_rdata  = next_rd_ff;
   assign stack_rdata = stack_rd_ff;

endmodule

FILE: hw/rtl/kdq_ctrl.sv
// Sequencer for deque operations with one shared identifier comparator.
module kdq_ctrl #(
   parameter int DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [2:0]                       req_operation,
   input  logic [7:0]                       req_letter,
   input  logic [7:0]                       req_score,
   input  logic [15:0]                      req_key_id,
   output logic                             res_valid,
   input  logic                             res_take,
   output kdq_pkg::result_type              res_data,
   output logic [$clog2(DEPTH+1)-1:0]       res_count,
   output kdq_pkg::mem_we_type              mem_we,
   output logic [$clog2(DEPTH)-1:0]         link_raddr,
   output logic [$clog2(DEPTH)-1:0]         stack_raddr,
   output logic [$clog2(DEPTH)-1:0]         entry_waddr,
   output kdq_pkg::entry_type               entry_wdata,
   output logic [$clog2(DEPTH)-1:0]         prev_waddr,
   output logic [$clog2(DEPTH)-1:0]         prev_wdata,
   output logic [$clog2(DEPTH)-1:0]         next_waddr,
   output logic [$clog2(DEPTH)-1:0]         next_wdata,
   output logic [$clog2(DEPTH)-1:0]         stack_waddr,
   output logic [$clog2(DEPTH)-1:0]         stack_wdata,
   input  kdq_pkg::entry_type               entry_rdata,
   input  logic [$clog2(DEPTH)-1:0]         prev_rdata,
   input  logic [$clog2(DEPTH)-1:0]         next_rdata,
   input  logic [$clog2(DEPTH)-1:0]         stack_rdata
);
   import kdq_pkg::*;

   localparam int SW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_START  = 3'd1;
   localparam logic [2:0] S_TAIL   = 3'd2;
   localparam logic [2:0] S_WALK   = 3'd3;
   localparam logic [2:0] S_REMOVE = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0]    state_ff,    state_in;
   logic [2:0]    op_ff,       op_in;
   logic [7:0]    letter_ff,   letter_in;
   logic [7:0]    score_ff,    score_in;
   logic [15:0]   key_ff,      key_in;
   logic [SW-1:0] head_ff,     head_in;
   logic [SW-1:0] tail_ff,     tail_in;
   logic [CW-1:0] count_ff,    count_in;
   logic [15:0]   next_id_ff,  next_id_in;
   logic [CW-1:0] fresh_ff,    fresh_in;
   logic [CW-1:0] sp_ff,       sp_in;
   logic [SW-1:0] cur_ff,      cur_in;
   logic [CW-1:0] walk_n_ff,   walk_n_in;
   logic [SW-1:0] slot_ff,     slot_in;
   logic          tail_hit_ff, tail_hit_in;
   result_type    res_ff,      res_in;

   logic [CW-1:0] stack_last;
   logic [SW-1:0] alloc_slot;
   logic          key_hit;

   // Pick a never-used slot first, then recycle from the free stack
   assign stack_last = sp_ff - ONE_C;
   assign alloc_slot = (fresh_ff != DEPTH_C) ? fresh_ff[SW-1:0] : stack_rdata;

   // Shared identifier comparator
   assign key_hit = (entry_rdata.ident == key_ff);

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res_data  = res_ff;
   assign res_count = count_ff;

   // Sequence one item through its steps
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      letter_in   = letter_ff;
      score_in    = score_ff;
      key_in      = key_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      next_id_in  = next_id_ff;
      fresh_in    = fresh_ff;
      sp_in       = sp_ff;
      cur_in      = cur_ff;
      walk_n_in   = walk_n_ff;
      slot_in     = slot_ff;
      tail_hit_in = tail_hit_ff;
      res_in      = res_ff;

      mem_we      = '0;
      link_raddr  = cur_ff;
      stack_raddr = stack_last[SW-1:0];
      entry_waddr = alloc_slot;
      entry_wdata = '{letter: letter_ff, score: score_ff, ident: next_id_ff};
      prev_waddr  = alloc_slot;
      prev_wdata  = tail_ff;
      next_waddr  = alloc_slot;
      next_wdata  = head_ff;
      stack_waddr = sp_ff[SW-1:0];
      stack_wdata = slot_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_operation;
               letter_in = req_letter;
               score_in  = req_score;
               key_in    = req_key_id;
               state_in  = S_START;
            end
         end

         S_START: begin
            unique case (op_ff)
               OP_INS_FRONT, OP_INS_BACK: begin
                  if (count_ff == DEPTH_C) begin
                     res_in   = '{status: ST_FULL, entry: '0};
                     state_in = S_DONE;
                  end else begin
                     mem_we.entry_we = 1'b1;
                     // Link the new slot in at the chosen end
                     if (count_ff == '0) begin
                        head_in = alloc_slot;
                        tail_in = alloc_slot;
                     end else if (op_ff == OP_INS_FRONT) begin
                        mem_we.next_we = 1'b1;
                        mem_we.prev_we = 1'b1;
                        next_waddr     = alloc_slot;
                        next_wdata     = head_ff;
                        prev_waddr     = head_ff;
                        prev_wdata     = alloc_slot;
                        head_in        = alloc_slot;
                     end else begin
                        mem_we.next_we = 1'b1;
                        mem_we.prev_we = 1'b1;
                        prev_waddr     = alloc_slot;
                        prev_wdata     = tail_ff;
                        next_waddr     = tail_ff;
                        next_wdata     = alloc_slot;
                        tail_in        = alloc_slot;
                     end
                     if (fresh_ff != DEPTH_C) begin
                        fresh_in = fresh_ff + ONE_C;
                     end else begin
                        sp_in = stack_last;
                     end
                     count_in   = count_ff + ONE_C;
                     next_id_in = next_id_ff + 16'd1;
                     res_in     = '{status: ST_OK, entry: entry_wdata};
                     state_in   = S_DONE;
                  end
               end

               OP_FIND, OP_REM_FRONT, OP_REM_BACK, OP_REM_KEY: begin
                  if (count_ff == '0) begin
                     res_in   = '{status: ST_EMPTY, entry: '0};
                     state_in = S_DONE;
                  end else begin
                     unique case (op_ff)
                        OP_FIND: begin
                           link_raddr = head_ff;
                           cur_in     = head_ff;
                           walk_n_in  = '0;
                           state_in   = S_WALK;
                        end
                        OP_REM_FRONT: begin
                           link_raddr = head_ff;
                           slot_in    = head_ff;
                           state_in   = S_REMOVE;
                        end
                        OP_REM_BACK: begin
                           link_raddr = tail_ff;
                           slot_in    = tail_ff;
                           state_in   = S_REMOVE;
                        end
                        default: begin
                           link_raddr = tail_ff;
                           state_in   = S_TAIL;
                        end
                     endcase
                  end
               end

               default: begin
                  res_in   = '{status: ST_OK, entry: '0};
                  state_in = S_DONE;
               end
            endcase
         end

         // Note whether the back entry matches, then walk from the front
         S_TAIL: begin
            tail_hit_in = key_hit;
            link_raddr  = head_ff;
            cur_in      = head_ff;
            walk_n_in   = '0;
            state_in    = S_WALK;
         end

         // Compare one entry per cycle, following next links
         S_WALK: begin
            priority if (key_hit) begin
               if (op_ff == OP_FIND) begin
                  res_in   = '{status: ST_OK, entry: entry_rdata};
                  state_in = S_DONE;
               end else begin
                  link_raddr = cur_ff;
                  slot_in    = cur_ff;
                  state_in   = S_REMOVE;
               end
            end else if (op_ff == OP_REM_KEY && walk_n_ff == '0 && tail_hit_ff) begin
               link_raddr = tail_ff;
               slot_in    = tail_ff;
               state_in   = S_REMOVE;
            end else if (walk_n_ff + ONE_C == count_ff) begin
               res_in   = '{status: ST_MISSING, entry: '0};
               state_in = S_DONE;
            end else begin
               link_raddr = next_rdata;
               cur_in     = next_rdata;
               walk_n_in  = walk_n_ff + ONE_C;
            end
         end

         // Unlink the slot and return it to the free stack
         S_REMOVE: begin
            res_in = '{status: ST_OK, entry: entry_rdata};
            priority if (count_ff <= ONE_C) begin
               head_in = '0;
               tail_in = '0;
            end else if (slot_ff == head_ff) begin
               head_in = next_rdata;
            end else if (slot_ff == tail_ff) begin
               tail_in = prev_rdata;
            end else begin
               mem_we.next_we = 1'b1;
               mem_we.prev_we = 1'b1;
               next_waddr     = prev_rdata;
               next_wdata     = next_rdata;
               prev_waddr     = next_rdata;
               prev_wdata     = prev_rdata;
            end
            mem_we.stack_we = 1'b1;
            sp_in           = sp_ff + ONE_C;
            count_in        = count_ff - ONE_C;
            state_in        = S_DONE;
         end

         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         head_ff    <= '0;
         tail_ff    <= '0;
         count_ff   <= '0;
         next_id_ff <= '0;
         fresh_ff   <= '0;
         sp_ff      <= '0;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         count_ff   <= count_in;
         next_id_ff <= next_id_in;
         fresh_ff   <= fresh_in;
         sp_ff      <= sp_in;
      end
   end

   // Item and walk payload
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      letter_ff   <= letter_in;
      score_ff    <= score_in;
      key_ff      <= key_in;
      cur_ff      <= cur_in;
      walk_n_ff   <= walk_n_in;
      slot_ff     <= slot_in;
      tail_hit_ff <= tail_hit_in;
      res_ff      <= res_in;
   end

endmodule

FILE: verif/keyed_deque_with_id_lookup_tb.sv
// Self-checking testbench for the keyed deque with identifier lookup.
module keyed_deque_with_id_lookup_tb;
   import kdq_pkg::*;

   localparam int DEPTH = 64;

   // Codes the block leaves unused: they must do nothing
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [1:0] status;
      entry_type  entry;
      logic [6:0] count;
   } deque_result_type;

   // Mirror of the deque contents, front first, and the results it predicts
   class deque_mirror;
      entry_type        held_entries[$];
      logic [15:0]      next_ident;
      deque_result_type outcomes_due[$];
      int               errors;

      function new();
         next_ident = '0;
         errors     = 0;
      endfunction

      // Find the first entry with this identifier, counted from the front
      function int front_index_of(logic [15:0] key);
         foreach (held_entries[i]) begin
            if (held_entries[i].ident == key) return i;
         end
         return -1;
      endfunction

      // Apply one accepted item to the mirror and queue its result
      function void apply_request(logic [2:0] op, logic [7:0] letter, logic [7:0] score,
                                  logic [15:0] key);
         deque_result_type res;
         int               pos;
         res        = '0;
         res.status = ST_OK;
         case (op)
            OP_INS_FRONT, OP_INS_BACK: begin
               if (held_entries.size() >= DEPTH) begin
                  res.status = ST_FULL;
               end else begin
                  res.entry.letter = letter;
                  res.entry.score  = score;
                  res.entry.ident  = next_ident;
                  if (op == OP_INS_FRONT) held_entries.push_front(res.entry);
                  else held_entries.push_back(res.entry);
                  next_ident = next_ident + 16'd1;
               end
            end
            OP_FIND, OP_REM_FRONT, OP_REM_BACK, OP_REM_KEY: begin
               if (held_entries.size() == 0) begin
                  res.status = ST_EMPTY;
               end else begin
                  case (op)
                     OP_FIND:      pos = front_index_of(key);
                     OP_REM_FRONT: pos = 0;
                     OP_REM_BACK:  pos = held_entries.size() - 1;
                     default: begin
                        // remove by key tests the front, then the back, then walks
                        if (held_entries[0].ident == key) pos = 0;
                        else if (held_entries[$].ident == key) pos = held_entries.size() - 1;
                        else pos = front_index_of(key);
                     end
                  endcase
                  if (pos < 0) begin
                     res.status = ST_MISSING;
                  end else begin
                     res.entry = held_entries[pos];
                     if (op != OP_FIND) held_entries.delete(pos);
                  end
               end
            end
            default: ;
         endcase
         res.count = 7'(held_entries.size());
         outcomes_due.push_back(res);
      endfunction

      function void compare_field(string field, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s expected %h, got %h", $time, field, want, got);
         end
      endfunction

      // Compare one accepted result with the oldest prediction
      function void check_response(logic [1:0] status, logic [7:0] letter, logic [7:0] score,
                                   logic [15:0] ident, logic [6:0] count);
         deque_result_type want;
         if (outcomes_due.size() == 0) begin
            errors++;
            $display("%0t: result with no item outstanding, expected none, got status %h",
                     $time, status);
            return;
         end
         want = outcomes_due.pop_front();
         compare_field("status", 16'(want.status), 16'(status));
         compare_field("entry_letter", 16'(want.entry.letter), 16'(letter));
         compare_field("entry_score", 16'(want.entry.score), 16'(score));
         compare_field("entry_id", want.entry.ident, ident);
         compare_field("entry_count", 16'(want.count), 16'(count));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_operation;
   logic [7:0]  req_letter;
   logic [7:0]  req_score;
   logic [15:0] req_key_id;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_entry_letter;
   logic [7:0]  rsp_entry_score;
   logic [15:0] rsp_entry_id;
   logic [6:0]  rsp_entry_count;

   deque_mirror mirror = new();

   bit sender_fast = 1'b0;
   bit sink_fast   = 1'b0;
   int burst_left  = 0;
   int long_hold   = 0;

   keyed_deque_with_id_lookup #(.DEPTH(DEPTH)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_letter       (req_letter),
      .req_score        (req_score),
      .req_key_id       (req_key_id),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_entry_letter (rsp_entry_letter),
      .rsp_entry_score  (rsp_entry_score),
      .rsp_entry_id     (rsp_entry_id),
      .rsp_entry_count  (rsp_entry_count)
   );

   always #10 clock = ~clock;

   // Random payload values at field width
   function automatic logic [7:0] rand_byte();
      return 8'($urandom);
   endfunction

   function automatic logic [15:0] rand_word();
      return 16'($urandom);
   endfunction

   // Offer one item at the falling edge and hold it until accepted
   task automatic issue(input logic [2:0] op, input logic [7:0] letter,
                        input logic [7:0] score, input logic [15:0] key);
      int gap;
      if (!sender_fast) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
               req_valid     <= 1'b0;
               req_operation <= 3'($urandom_range(0, 7));
               req_letter    <= rand_byte();
               req_score     <= rand_byte();
               req_key_id    <= rand_word();
               repeat (gap) @(negedge clock);
            end
         end
         burst_left--;
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_letter    <= letter;
      req_score     <= score;
      req_key_id    <= key;
      do @(posedge clock); while (!req_ready);
      mirror.apply_request(op, letter, score, key);
      @(negedge clock);
   endtask

   // Check every accepted result
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         mirror.check_response(rsp_status, rsp_entry_letter, rsp_entry_score,
                               rsp_entry_id, rsp_entry_count);
   end

   // Receiver pacing: long hold on request, else a changing stall pattern
   initial begin : sink_pacing
      int mode;
      int left;
      mode      = 0;
      left      = 0;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold > 0) begin
            rsp_ready <= 1'b0;
            long_hold--;
         end else if (sink_fast) begin
            rsp_ready <= 1'b1;
         end else begin
            if (left == 0) begin
               mode = $urandom_range(0, 2);
               left = $urandom_range(10, 90);
            end
            left--;
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= ((left % 7) >= 3);
            endcase
         end
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int          phase_left;
      int          ins_pct;
      logic [2:0]  op;
      logic [15:0] key;
      logic [15:0] first_id;
      clock         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_operation = '0;
      req_letter    = '0;
      req_score     = '0;
      req_key_id    = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty list, unused codes, field extremes, single-entry removals
      issue(OP_FIND, 8'h00, 8'h00, 16'h0000);
      issue(OP_REM_FRONT, 8'hFF, 8'hFF, 16'hFFFF);
      issue(OP_REM_BACK, 8'h00, 8'h00, 16'h0000);
      issue(OP_REM_KEY, 8'hFF, 8'hFF, 16'hFFFF);
      issue(OP_SPARE_6, 8'hFF, 8'hFF, 16'hFFFF);
      issue(OP_INS_FRONT, 8'h00, 8'h00, 16'hFFFF);
      issue(OP_INS_BACK, 8'hFF, 8'hFF, 16'h0000);
      issue(OP_INS_FRONT, 8'hA5, 8'h5A, 16'h1234);
      issue(OP_SPARE_7, 8'h00, 8'h00, 16'h0000);
      issue(OP_FIND, 8'h00, 8'h00, 16'h0000);
      issue(OP_FIND, 8'h00, 8'h00, 16'h0002);
      issue(OP_FIND, 8'h00, 8'h00, 16'h0001);
      issue(OP_FIND, 8'h00, 8'h00, 16'hFFFF);
      issue(OP_REM_KEY, 8'h00, 8'h00, 16'hFFFF);
      issue(OP_REM_KEY, 8'h00, 8'h00, 16'h0000);
      issue(OP_REM_KEY, 8'h00, 8'h00, 16'h0001);
      issue(OP_REM_KEY, 8'h00, 8'h00, 16'h0002);
      issue(OP_INS_BACK, 8'h80, 8'h01, 16'h5555);
      issue(OP_REM_FRONT, 8'h00, 8'h00, 16'h0000);
      issue(OP_INS_FRONT, 8'h01, 8'h80, 16'hAAAA);
      issue(OP_REM_BACK, 8'h00, 8'h00, 16'h0000);
      issue(OP_INS_BACK, 8'h7F, 8'hFE, 16'h0000);
      issue(OP_INS_BACK, 8'hFE, 8'h7F, 16'h0000);
      issue(OP_REM_FRONT, 8'h00, 8'h00, 16'h0000);
      issue(OP_REM_BACK, 8'h00, 8'h00, 16'h0000);

      // Fill to capacity, get rejected, then keep three entries
      sender_fast = 1'b1;
      sink_fast   = 1'b1;
      while (mirror.held_entries.size() < DEPTH)
         issue(OP_INS_BACK, rand_byte(), rand_byte(), rand_word());
      issue(OP_INS_FRONT, rand_byte(), rand_byte(), rand_word());
      issue(OP_INS_BACK, rand_byte(), rand_byte(), rand_word());
      while (mirror.held_entries.size() > 3)
         issue(OP_REM_FRONT, rand_byte(), rand_byte(), rand_word());
      first_id = mirror.held_entries[0].ident;
      sender_fast = 1'b0;
      sink_fast   = 1'b0;

      // Look up and remove identifiers in the middle, then ones already gone
      issue(OP_INS_FRONT, rand_byte(), rand_byte(), rand_word());
      issue(OP_INS_BACK, rand_byte(), rand_byte(), rand_word());
      issue(OP_INS_FRONT, rand_byte(), rand_byte(), rand_word());
      issue(OP_INS_BACK, rand_byte(), rand_byte(), rand_word());
      issue(OP_INS_FRONT, rand_byte(), rand_byte(), rand_word());
      issue(OP_FIND, rand_byte(), rand_byte(), first_id);
      issue(OP_FIND, rand_byte(), rand_byte(), first_id + 16'd2);
      issue(OP_FIND, rand_byte(), rand_byte(), first_id + 16'd1);
      issue(OP_REM_KEY, rand_byte(), rand_byte(), first_id + 16'd1);
      issue(OP_REM_KEY, rand_byte(), rand_byte(), first_id);
      issue(OP_REM_KEY, rand_byte(), rand_byte(), first_id + 16'd2);
      issue(OP_REM_KEY, rand_byte(), rand_byte(), first_id + 16'd2);
      issue(OP_FIND, rand_byte(), rand_byte(), first_id + 16'd2);

      // Random phases that lean toward growth, balance or shrinking
      phase_left = 0;
      ins_pct    = 50;
      for (int n = 0; n < 690; n++) begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(30, 120);
            case ($urandom_range(0, 2))
               0:       ins_pct = 20;
               1:       ins_pct = 50;
               default: ins_pct = 85;
            endcase
         end
         phase_left--;
         // stall the receiver long enough to back the block up
         if (n == 400) long_hold = 300;
         if ($urandom_range(0, 99) < 3) begin
            op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
         end else if ($urandom_range(0, 99) < ins_pct) begin
            op = $urandom_range(0, 1) ? OP_INS_FRONT : OP_INS_BACK;
         end else begin
            case ($urandom_range(0, 3))
               0:       op = OP_FIND;
               1:       op = OP_REM_FRONT;
               2:       op = OP_REM_BACK;
               default: op = OP_REM_KEY;
            endcase
         end
         // mostly look up identifiers that are held, sometimes any value
         if (mirror.held_entries.size() > 0 && $urandom_range(0, 3) != 0)
            key = mirror.held_entries[$urandom_range(0, mirror.held_entries.size() - 1)].ident;
         else
            key = rand_word();
         issue(op, rand_byte(), rand_byte(), key);
      end

      // Drain and let any stray result show up
      req_valid <= 1'b0;
      while (mirror.outcomes_due.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (mirror.errors == 0)
         $display("keyed_deque_with_id_lookup: match");
      else
         $display("keyed_deque_with_id_lookup: mismatch");
      $finish;
   end

   initial begin : watchdog
      #100_000_000;
      $display("keyed_deque_with_id_lookup: mismatch");
      $finish;
   end

endmodule
